[sv/kdlp_pkg.sv]
// Package for the keypad debounce and long-press block.
// Holds shared types, register indexes, reset values and the keymap.
// No dependencies.
package kdlp_pkg;

  // Key code 16 marks "no key"; 0..15 are row*4+column.
  localparam logic [4:0] NO_KEY   = 5'd16;
  localparam logic [15:0] HOLD_MAX = 16'hFFFF;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [3:0]  DEBOUNCE_RST = 4'd3;
  localparam logic [15:0] LONG_RST     = 16'd200;

  // Event kinds.
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_kind_t;

  // One result item.
  typedef struct packed {
    event_kind_t kind;
    logic [3:0]  key;
    logic [6:0]  ch;
    logic [4:0]  held;
  } result_t;

  // ASCII character of each key, laid out as the keypad face.
  function automatic logic [6:0] key_char(input logic [3:0] key);
    logic [6:0] c;
    case (key)
      4'd0:    c = 7'h31; // '1'
      4'd1:    c = 7'h32; // '2'
      4'd2:    c = 7'h33; // '3'
      4'd3:    c = 7'h41; // 'A'
      4'd4:    c = 7'h34; // '4'
      4'd5:    c = 7'h35; // '5'
      4'd6:    c = 7'h36; // '6'
      4'd7:    c = 7'h42; // 'B'
      4'd8:    c = 7'h37; // '7'
      4'd9:    c = 7'h38; // '8'
      4'd10:   c = 7'h39; // '9'
      4'd11:   c = 7'h43; // 'C'
      4'd12:   c = 7'h2A; // '*'
      4'd13:   c = 7'h30; // '0'
      4'd14:   c = 7'h23; // '#'
      default: c = 7'h44; // 'D'
    endcase
    return c;
  endfunction

endpackage

[sv/kdlp_decode.sv]
// Raw key decode for one scan of the 4x4 keypad.
// Depends on kdlp_pkg for the no-key code.
module kdlp_decode (
  input  logic [15:0] scan,     // row0_cols, row1_cols, row2_cols, row3_cols from bit 0 up
  output logic [4:0]  raw_key
);

  logic [3:0] low [4];
  logic [3:0] active;

  // Columns are active low; a row is active when any column is pulled low.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      low[r]    = ~scan[r*4 +: 4];
      active[r] = |low[r];
    end
  end

  // The first active row decides; more than one low column means no key.
  always_comb begin
    logic       found;
    logic [1:0] row;
    logic [3:0] sel;
    found   = 1'b0;
    row     = 2'd0;
    raw_key = kdlp_pkg::NO_KEY;
    for (int r = 0; r < 4; r++) begin
      if (!found && active[r]) begin
        found = 1'b1;
        row   = 2'(r);
      end
    end
    sel = low[row];
    if (found && ((sel & (sel - 4'd1)) == 4'd0)) begin
      case (sel)
        4'b0001: raw_key = {1'b0, row, 2'd0};
        4'b0010: raw_key = {1'b0, row, 2'd1};
        4'b0100: raw_key = {1'b0, row, 2'd2};
        default: raw_key = {1'b0, row, 2'd3};
      endcase
    end
  end

endmodule

[sv/kdlp_core.sv]
// Debounce, hold counting and press-event logic, one scan per step.
// Depends on kdlp_pkg for codes, the result type and the keymap.
module kdlp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [4:0]          raw_key,
  input  logic [3:0]          debounce_scans,
  input  logic [15:0]         long_press_scans,
  output kdlp_pkg::result_t   result
);

  logic [4:0]  cand_key_r, cand_key_nxt;
  logic [3:0]  cand_cnt_r, cand_cnt_nxt;
  logic [4:0]  conf_key_r, conf_key_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic        long_done_r, long_done_nxt;

  // Next state and event for the scan at the input.
  always_comb begin
    logic        confirm;
    logic        key_edge;
    logic [15:0] hold_base;
    logic        long_base;
    kdlp_pkg::event_kind_t kind;
    logic [3:0]  key;

    kind = kdlp_pkg::EV_NONE;
    key  = 4'd0;

    // Candidate tracking: count saturates at the debounce setting.
    cand_key_nxt = raw_key;
    if (raw_key == cand_key_r) begin
      cand_cnt_nxt = (cand_cnt_r < debounce_scans) ? cand_cnt_r + 4'd1 : cand_cnt_r;
    end else begin
      cand_cnt_nxt = 4'd1;
    end

    // Confirmation of a new stable state.
    confirm      = (cand_cnt_nxt >= debounce_scans) && (conf_key_r != raw_key);
    conf_key_nxt = confirm ? raw_key : conf_key_r;
    key_edge     = confirm && (raw_key != kdlp_pkg::NO_KEY);
    hold_base    = key_edge ? 16'd0 : hold_r;
    long_base    = key_edge ? 1'b0 : long_done_r;

    // Release of a key that did not reach a long press.
    if (confirm && (raw_key == kdlp_pkg::NO_KEY) && !long_done_r &&
        (conf_key_r != kdlp_pkg::NO_KEY)) begin
      kind = kdlp_pkg::EV_SHORT;
      key  = conf_key_r[3:0];
    end

    // Hold counting and the one-shot long press.
    hold_nxt      = hold_base;
    long_done_nxt = long_base;
    if (conf_key_nxt != kdlp_pkg::NO_KEY) begin
      if (!key_edge && (hold_base != kdlp_pkg::HOLD_MAX)) begin
        hold_nxt = hold_base + 16'd1;
      end
      if (!long_base && (hold_nxt >= long_press_scans)) begin
        long_done_nxt = 1'b1;
        kind          = kdlp_pkg::EV_LONG;
        key           = conf_key_nxt[3:0];
      end
    end

    result.kind = kind;
    result.key  = key;
    result.ch   = (kind != kdlp_pkg::EV_NONE) ? kdlp_pkg::key_char(key) : 7'd0;
    result.held = conf_key_nxt;
  end

  // Tracking state advances once per processed scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_key_r  <= kdlp_pkg::NO_KEY;
      cand_cnt_r  <= 4'd0;
      conf_key_r  <= kdlp_pkg::NO_KEY;
      hold_r      <= 16'd0;
      long_done_r <= 1'b0;
    end else if (step) begin
      cand_key_r  <= cand_key_nxt;
      cand_cnt_r  <= cand_cnt_nxt;
      conf_key_r  <= conf_key_nxt;
      hold_r      <= hold_nxt;
      long_done_r <= long_done_nxt;
    end
  end

endmodule

[sv/keypad_debounce_long_press_top.sv]
// Top level of the keypad scanner with debounce and long-press events.
// Depends on kdlp_pkg, kdlp_decode and kdlp_core.
//
// Usage:
//   Each input transaction on in_* is one scan of a 4x4 keypad: four
//   active-low column nibbles, one per driven row. Each scan yields exactly
//   one output transaction on out_*, carrying the event kind (none, short
//   press on release, long press), the event key and its ASCII character,
//   and the debounced key currently held (16 when none).
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while the
//   block is idle: index 0 sets the debounce count, index 1 the long-press
//   hold length, both counted in scans.
// Timing:
//   A scan is captured in an input register, and the debounce state and
//   the result are computed from it combinationally into the output
//   register. One scan is taken every cycle while the receiver keeps
//   out_tready high; the tracking state update loop sets this rate.
// Reset and stalls:
//   rst_n (synchronous) empties both registers, clears the tracking state
//   to no key and reloads the configuration defaults (3 and 200). When the
//   receiver holds out_tready low, the output register and then the input
//   register fill, and in_tready drops until a result is taken.
module keypad_debounce_long_press_top (
  input  logic        clk,
  input  logic        rst_n,
  // Scan input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // row0_cols, row1_cols, row2_cols, row3_cols
  // Event output channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // event_key, event_char, held_key
  output logic [1:0]  out_tuser,  // event_kind
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [kdlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [3:0]  debounce_r;
  logic [15:0] long_press_r;

  logic        in_valid_r;
  logic [15:0] in_data_r;
  logic        out_valid_r;
  kdlp_pkg::result_t out_data_r;

  logic        step;
  logic [4:0]  raw_key;
  kdlp_pkg::result_t result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= kdlp_pkg::DEBOUNCE_RST;
      long_press_r <= kdlp_pkg::LONG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        kdlp_pkg::REG_DEBOUNCE: debounce_r   <= cfg_wdata[3:0];
        kdlp_pkg::REG_LONG:     long_press_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A scan is processed when the output register is free or being emptied.
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
  end

  kdlp_decode u_decode (
    .scan    (in_data_r),
    .raw_key (raw_key)
  );

  kdlp_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .raw_key          (raw_key),
    .debounce_scans   (debounce_r),
    .long_press_scans (long_press_r),
    .result           (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_data_r.kind;
  assign out_tdata  = {out_data_r.held, out_data_r.ch, out_data_r.key};

endmodule

[tb/tb_keypad_debounce_long_press_top.sv]
// Self-checking testbench for keypad_debounce_long_press_top.
// Predicts every event result from its own model of the debounce and hold logic.
// Depends on kdlp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_keypad_debounce_long_press_top;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  // Keypad face, one ASCII byte per key, key 0 in the top byte.
  localparam logic [127:0] KEY_FACE = "123A456B789C*0#D";

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = 16'h0000;   // row0_cols, row1_cols, row2_cols, row3_cols
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;             // event_key, event_char, held_key
  logic [1:0] out_tuser;              // event_kind
  logic cfg_we = 1'b0;
  logic [kdlp_pkg::CFG_IDX_W-1:0] cfg_index = kdlp_pkg::REG_DEBOUNCE;
  logic [15:0] cfg_wdata = 16'h0000;

  // Predictor copy of the configuration and the tracking state.
  logic [3:0] deb_scans = kdlp_pkg::DEBOUNCE_RST;
  logic [15:0] long_scans = kdlp_pkg::LONG_RST;
  logic [4:0] cand_key = kdlp_pkg::NO_KEY;
  logic [3:0] cand_run = 4'd0;
  logic [4:0] held = kdlp_pkg::NO_KEY;
  logic [15:0] hold_count = 16'd0;
  logic long_fired = 1'b0;

  kdlp_pkg::result_t pending_events[$];
  int unsigned scans_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  logic idle_on = 1'b1;

  keypad_debounce_long_press_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (roll < 20) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else if (roll < 23) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(8, 40);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // The first row with any low column decides; two or more low columns there mean no key.
  function automatic logic [4:0] key_of_scan(input logic [15:0] scan);
    logic [3:0] low;
    logic [4:0] k;
    k = kdlp_pkg::NO_KEY;
    for (int r = 3; r >= 0; r--) begin
      low = ~scan[r*4 +: 4];
      if (low != 4'd0) begin
        if ((low & (low - 4'd1)) != 4'd0) begin
          k = kdlp_pkg::NO_KEY;
        end else begin
          for (int c = 0; c < 4; c++)
            if (low[c]) k = 5'(r * 4 + c);
        end
      end
    end
    return k;
  endfunction

  function automatic logic [6:0] face_char(input logic [3:0] k);
    return KEY_FACE[8 * (15 - int'(k)) +: 7];
  endfunction

  // Advances the debounce and hold state by one scan and returns the event it gives.
  function automatic kdlp_pkg::result_t next_event(input logic [15:0] scan);
    kdlp_pkg::result_t res;
    logic [4:0] raw;
    logic [4:0] prev;
    logic [3:0] ev_key;
    kdlp_pkg::event_kind_t kind;
    logic rise;
    raw = key_of_scan(scan);
    kind = kdlp_pkg::EV_NONE;
    ev_key = 4'd0;
    rise = 1'b0;
    if (raw == cand_key) begin
      if (cand_run < deb_scans) cand_run = cand_run + 4'd1;
    end else begin
      cand_key = raw;
      cand_run = 4'd1;
    end
    if (cand_run >= deb_scans && held != cand_key) begin
      prev = held;
      held = cand_key;
      if (held != kdlp_pkg::NO_KEY) begin
        hold_count = 16'd0;
        long_fired = 1'b0;
        rise = 1'b1;
      end else if (!long_fired && prev < kdlp_pkg::NO_KEY) begin
        kind = kdlp_pkg::EV_SHORT;
        ev_key = prev[3:0];
      end
    end
    if (held != kdlp_pkg::NO_KEY) begin
      if (!rise && hold_count != kdlp_pkg::HOLD_MAX) hold_count = hold_count + 16'd1;
      if (!long_fired && hold_count >= long_scans) begin
        long_fired = 1'b1;
        kind = kdlp_pkg::EV_LONG;
        ev_key = held[3:0];
      end
    end
    res.kind = kind;
    res.key = (kind != kdlp_pkg::EV_NONE) ? ev_key : 4'd0;
    res.ch = (kind != kdlp_pkg::EV_NONE) ? face_char(ev_key) : 7'd0;
    res.held = held;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want_v, got_v);
    mismatches++;
  endtask

  // Compare each output transaction with the oldest prediction.
  always @(posedge clk) begin
    kdlp_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected result", 0, int'(out_tdata));
      end else begin
        want = pending_events.pop_front();
        if (out_tuser != want.kind) report_mismatch("event_kind", want.kind, out_tuser);
        if (out_tdata[3:0] != want.key) report_mismatch("event_key", want.key, out_tdata[3:0]);
        if (out_tdata[10:4] != want.ch) report_mismatch("event_char", want.ch, out_tdata[10:4]);
        if (out_tdata[15:11] != want.held)
          report_mismatch("held_key", want.held, out_tdata[15:11]);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Sends one scan transaction and records its predicted event.
  task automatic send_scan(input logic [15:0] scan);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= scan;
    do @(posedge clk); while (!in_tready);
    pending_events.push_back(next_event(scan));
    scans_sent++;
  endtask

  // Scan that decodes to key k; rows below the key's row carry random bits.
  function automatic logic [15:0] key_scan(input int unsigned k);
    logic [15:0] s;
    int unsigned row;
    s = 16'($urandom);
    row = k / 4;
    for (int i = 0; i < 4; i++)
      if (i < row) s[i*4 +: 4] = 4'hF;
    s[row*4 +: 4] = ~(4'b0001 << (k % 4));
    return s;
  endfunction

  // Scan that decodes to no key: all released, or two lows in the first active row.
  function automatic logic [15:0] nokey_scan();
    logic [15:0] s;
    logic [3:0] nib;
    int unsigned row;
    row = $urandom_range(0, 4);
    if (row == 4) return 16'hFFFF;
    s = 16'($urandom);
    do nib = 4'($urandom); while ($countones(~nib) < 2);
    for (int i = 0; i < 4; i++)
      if (i < row) s[i*4 +: 4] = 4'hF;
    s[row*4 +: 4] = nib;
    return s;
  endfunction

  // Waits until every result is back and the pipeline has emptied.
  task automatic drain_events();
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] deb, input logic [15:0] lng);
    drain_events();
    cfg_we <= 1'b1;
    cfg_index <= kdlp_pkg::REG_DEBOUNCE;
    cfg_wdata <= {12'd0, deb};
    @(posedge clk);
    cfg_index <= kdlp_pkg::REG_LONG;
    cfg_wdata <= lng;
    @(posedge clk);
    cfg_we <= 1'b0;
    deb_scans = deb;
    long_scans = lng;
  endtask

  // Reset settings: press key 0 long enough to confirm, then release for a short press.
  task automatic test_reset_defaults();
    send_scan(16'hFFFF);
    repeat (3) send_scan(16'hFFFE);
    repeat (3) send_scan(16'hFFFF);
    send_scan(16'h0000);
  endtask

  // Long press, release after long press, row priority, double press,
  // key to key change, and the zero settings.
  task automatic test_directed_events();
    set_config(4'd1, 16'd2);
    repeat (3) send_scan(16'h7FFF);
    send_scan(16'hFFFF);
    send_scan(16'hFEF7);
    send_scan(16'hFFCF);
    send_scan(16'hFFDF);
    send_scan(16'hFFBF);
    send_scan(16'hFFFF);
    set_config(4'd0, 16'd0);
    send_scan(16'hEFFF);
    send_scan(16'hFFFF);
    send_scan(16'h0F0F);
    send_scan(16'hF0FF);
    send_scan(16'hFDFF);
    send_scan(16'hFFFF);
  endtask

  function automatic int unsigned pick_hold();
    int near;
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, deb_scans + 2);
      1: begin
        near = int'(deb_scans) + ((long_scans < 100) ? int'(long_scans) : 100)
               + int'($urandom_range(0, 2)) - 1;
        return (near < 1) ? 1 : near;
      end
      2: return $urandom_range(1, 12);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // Random press and release sequences under one setting, with bounce and noise mixed in.
  task automatic test_random_presses(input logic [3:0] deb, input logic [15:0] lng,
                                     input int unsigned n_scans);
    int unsigned stop_at;
    int unsigned roll;
    int unsigned k;
    int unsigned k2;
    set_config(deb, lng);
    stop_at = scans_sent + n_scans;
    while (scans_sent < stop_at) begin
      idle_on <= ($urandom_range(0, 9) != 0);
      roll = $urandom_range(0, 99);
      k = $urandom_range(0, 15);
      if (roll < 70) begin
        repeat (pick_hold()) send_scan(key_scan(k));
        repeat ($urandom_range(0, deb_scans + 3)) send_scan(nokey_scan());
      end else if (roll < 82) begin
        k2 = $urandom_range(0, 15);
        repeat (pick_hold()) send_scan(key_scan(k));
        repeat (pick_hold()) send_scan(key_scan(k2));
        repeat ($urandom_range(1, deb_scans + 3)) send_scan(nokey_scan());
      end else if (roll < 92) begin
        repeat ($urandom_range(2, 6)) begin
          repeat ($urandom_range(1, 2)) send_scan(key_scan(k));
          repeat ($urandom_range(1, 2)) send_scan(nokey_scan());
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_scan(16'($urandom));
      end
    end
    idle_on <= 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed_events();
    test_random_presses(4'd1, 16'd1, 200);
    test_random_presses(4'd2, 16'd6, 250);
    test_random_presses(4'd15, 16'hFFFF, 150);
    test_random_presses(4'd15, 16'd1, 150);
    test_random_presses(4'd0, 16'd0, 150);
    test_random_presses(4'd4, 16'd30, 250);
    test_random_presses(4'($urandom_range(0, 8)), 16'($urandom_range(0, 40)), 200);
    drain_events();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
